@@ hdl/rvdp_pkg.sv @@
package rvdp_pkg;

   localparam int CsrIdxW = 8;
   localparam int PcW     = 5;

   localparam logic [CsrIdxW-1:0] CsrStep = 8'd0;
   localparam logic [CsrIdxW-1:0] CsrMu   = 8'd1;

   localparam logic [24:0] StepReset = 25'd167772;
   localparam logic [28:0] MuReset   = 29'd16777216;

   localparam logic signed [31:0] QOne    = 32'sd16777216;
   localparam logic signed [63:0] QHalf   = 64'sd8388608;
   localparam logic signed [39:0] S32Max  = 40'sd2147483647;
   localparam logic signed [39:0] S32Min  = -40'sd2147483648;
   localparam logic signed [36:0] DivBias = 37'sd25769803776;
   localparam logic signed [36:0] DivOff  = 37'sd8589934592;

   localparam logic [PcW-1:0] LoopTop = 5'd0;

   typedef enum logic [1:0] {A_TP, A_MU, A_H, A_R} asel_type;
   typedef enum logic [1:0] {B_TP, B_R, B_TV} bsel_type;
   typedef enum logic [1:0] {WB_NONE, WB_R, WB_KP, WB_KV} wb_type;
   typedef enum logic [2:0] {OP_NONE, OP_OM, OP_DV, OP_UPD, OP_PREP, OP_DIV, OP_FIN} op_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_DONE} jmp_type;
   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

   typedef struct packed {
      logic     mul_en;
      asel_type asel;
      bsel_type bsel;
      wb_type   wb;
      op_type   op;
      jmp_type  jmp;
   } uword_type;

   typedef struct packed {
      logic      accept;
      logic      load;
      uword_type uw;
   } ctrl_type;

   typedef struct packed {
      logic last_stage;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic              hit;
      logic signed [31:0] val;
   } sat_type;

   localparam uword_type UwNop = '{mul_en: 1'b0, asel: A_TP, bsel: B_TP, wb: WB_NONE,
                                   op: OP_NONE, jmp: JMP_NEXT};

   function automatic sat_type clamp32(input logic signed [39:0] v);
      sat_type s;
      if (v > S32Max) begin
         s.hit = 1'b1;
         s.val = 32'sh7fffffff;
      end else if (v < S32Min) begin
         s.hit = 1'b1;
         s.val = 32'sh80000000;
      end else begin
         s.hit = 1'b0;
         s.val = v[31:0];
      end
      return s;
   endfunction

   // six quotient bits of a divide by three, remainder carried in and out
   function automatic logic [7:0] div3_chunk(input logic [1:0] rem, input logic [5:0] bits);
      logic [2:0] t;
      logic [1:0] r;
      logic [5:0] q;
      integer     j;
      r = rem;
      q = '0;
      for (j = 5; j >= 0; j--) begin
         t = {r, bits[j]};
         if (t >= 3'd3) begin
            q[j] = 1'b1;
            r = 2'(t - 3'd3);
         end else begin
            q[j] = 1'b0;
            r = t[1:0];
         end
      end
      return {r, q};
   endfunction

   function automatic uword_type ucode(input logic [PcW-1:0] pc);
      uword_type u;
      u = UwNop;
      case (pc)
         5'd0: begin
            u.mul_en = 1'b1; u.asel = A_TP; u.bsel = B_TP;
         end
         5'd1: u.wb = WB_R;
         5'd2: u.op = OP_OM;
         5'd3: begin
            u.mul_en = 1'b1; u.asel = A_MU; u.bsel = B_R;
         end
         5'd4: begin
            u.wb = WB_R; u.mul_en = 1'b1; u.asel = A_H; u.bsel = B_TV;
         end
         5'd5: begin
            u.wb = WB_KP; u.mul_en = 1'b1; u.asel = A_R; u.bsel = B_TV;
         end
         5'd6: u.wb = WB_R;
         5'd7: u.op = OP_DV;
         5'd8: begin
            u.mul_en = 1'b1; u.asel = A_H; u.bsel = B_R;
         end
         5'd9: u.wb = WB_KV;
         5'd10: begin
            u.op = OP_UPD; u.jmp = JMP_LOOP;
         end
         5'd11: u.op = OP_PREP;
         5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: u.op = OP_DIV;
         5'd18: begin
            u.op = OP_FIN; u.jmp = JMP_DONE;
         end
         default: u = UwNop;
      endcase
      return u;
   endfunction

endpackage

@@ hdl/rvdp_if.sv @@
interface rvdp_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] load_position;
   logic signed [31:0] load_velocity;
   modport source (output valid, action, load_position, load_velocity, input ready);
   modport sink (input valid, action, load_position, load_velocity, output ready);
endinterface

interface rvdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_position;
   logic signed [31:0] new_velocity;
   logic               saturated;
   modport source (output valid, new_position, new_velocity, saturated, input ready);
   modport sink (input valid, new_position, new_velocity, saturated, output ready);
endinterface

interface rvdp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rvdp_pkg::CsrIdxW-1:0] index;
   logic [31:0]                   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/rvdp_seq.sv @@
module rvdp_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   input  rvdp_pkg::stat_type  stat,
   output logic                req_ready,
   output rvdp_pkg::ctrl_type  ctrl
);
   import rvdp_pkg::*;

   seq_state_type  state_ff, state_in;
   logic [PcW-1:0] pc_ff, pc_in;
   uword_type      uw_rom;
   logic           hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      uw_rom      = ucode(pc_ff);
      hold        = (uw_rom.op == OP_FIN) && !stat.out_free;
      state_in    = state_ff;
      pc_in       = pc_ff;
      req_ready   = 1'b0;
      ctrl.accept = 1'b0;
      ctrl.load   = req_action;
      ctrl.uw     = UwNop;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               ctrl.accept = 1'b1;
               if (!req_action) begin
                  state_in = SEQ_RUN;
                  pc_in    = '0;
               end
            end
         end
         SEQ_RUN: begin
            if (!hold) begin
               ctrl.uw = uw_rom;
               case (uw_rom.jmp)
                  JMP_NEXT: pc_in = pc_ff + 5'd1;
                  JMP_LOOP: pc_in = stat.last_stage ? pc_ff + 5'd1 : LoopTop;
                  JMP_DONE: begin
                     state_in = SEQ_IDLE;
                     pc_in    = '0;
                  end
                  default: pc_in = '0;
               endcase
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

@@ hdl/rvdp_dpath.sv @@
module rvdp_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  rvdp_pkg::ctrl_type          ctrl,
   input  logic signed [31:0]          load_position,
   input  logic signed [31:0]          load_velocity,
   input  logic                        csr_valid,
   input  logic [rvdp_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                 csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [31:0]          new_position,
   output logic signed [31:0]          new_velocity,
   output logic                        saturated,
   output rvdp_pkg::stat_type          stat
);
   import rvdp_pkg::*;

   logic signed [31:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [31:0] tp_ff, tp_in, tv_ff, tv_in, r_ff, r_in;
   logic signed [31:0] kp_ff, kp_in, kv_ff, kv_in;
   logic signed [35:0] sp_ff, sp_in, sv_ff, sv_in;
   logic [35:0]        dnp_ff, dnp_in, dnv_ff, dnv_in;
   logic [1:0]         remp_ff, remp_in, remv_ff, remv_in;
   logic [1:0]         stage_ff, stage_in;
   logic               sat_ff, sat_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [24:0]        step_ff;
   logic [28:0]        mu_ff;
   logic signed [31:0] opos_ff, opos_in, ovel_ff, ovel_in;
   logic               osat_ff, osat_in, ovld_ff, ovld_in;

   logic signed [31:0] ma, mb, mu_eff, h_ext, half_p, half_v;
   logic signed [63:0] rnd;
   logic signed [35:0] kp36, kv36, base_p, base_v;
   logic signed [36:0] pre_p, pre_v, qp, qv;
   logic [7:0]         dc_p, dc_v;
   logic               weight2;
   sat_type            c_wb, c_a, c_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vel_ff  <= '0;
         step_ff <= StepReset;
         mu_ff   <= MuReset;
         ovld_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         vel_ff  <= vel_in;
         ovld_ff <= ovld_in;
         if (csr_valid && csr_index == CsrStep) begin
            step_ff <= csr_data[24:0];
         end
         if (csr_valid && csr_index == CsrMu) begin
            mu_ff <= csr_data[28:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      tp_ff    <= tp_in;
      tv_ff    <= tv_in;
      r_ff     <= r_in;
      kp_ff    <= kp_in;
      kv_ff    <= kv_in;
      sp_ff    <= sp_in;
      sv_ff    <= sv_in;
      dnp_ff   <= dnp_in;
      dnv_ff   <= dnv_in;
      remp_ff  <= remp_in;
      remv_ff  <= remv_in;
      stage_ff <= stage_in;
      sat_ff   <= sat_in;
      prod_ff  <= prod_in;
      opos_ff  <= opos_in;
      ovel_ff  <= ovel_in;
      osat_ff  <= osat_in;
   end

   always_comb begin
      mu_eff = (mu_ff == '0) ? QOne : $signed({3'b000, mu_ff});
      h_ext  = $signed({7'b0000000, step_ff});

      case (ctrl.uw.asel)
         A_TP:    ma = tp_ff;
         A_MU:    ma = mu_eff;
         A_H:     ma = h_ext;
         A_R:     ma = r_ff;
         default: ma = tp_ff;
      endcase
      case (ctrl.uw.bsel)
         B_TP:    mb = tp_ff;
         B_R:     mb = r_ff;
         B_TV:    mb = tv_ff;
         default: mb = tp_ff;
      endcase

      rnd     = (prod_ff + QHalf) >>> 24;
      c_wb    = clamp32(rnd[39:0]);
      weight2 = (stage_ff == 2'd1) || (stage_ff == 2'd2);
      half_p  = (stage_ff == 2'd2) ? kp_ff : (kp_ff >>> 1);
      half_v  = (stage_ff == 2'd2) ? kv_ff : (kv_ff >>> 1);
      kp36    = 36'(kp_ff);
      kv36    = 36'(kv_ff);
      base_p  = (stage_ff == 2'd0) ? 36'sd0 : sp_ff;
      base_v  = (stage_ff == 2'd0) ? 36'sd0 : sv_ff;
      pre_p   = 37'((sp_ff + 36'sd3) >>> 1) + DivBias;
      pre_v   = 37'((sv_ff + 36'sd3) >>> 1) + DivBias;
      qp      = $signed({1'b0, dnp_ff}) - DivOff;
      qv      = $signed({1'b0, dnv_ff}) - DivOff;
      dc_p    = div3_chunk(remp_ff, dnp_ff[35:30]);
      dc_v    = div3_chunk(remv_ff, dnv_ff[35:30]);
      c_a     = clamp32(40'(pos_ff) + 40'(half_p));
      c_b     = clamp32(40'(vel_ff) + 40'(half_v));

      pos_in   = pos_ff;
      vel_in   = vel_ff;
      tp_in    = tp_ff;
      tv_in    = tv_ff;
      r_in     = r_ff;
      kp_in    = kp_ff;
      kv_in    = kv_ff;
      sp_in    = sp_ff;
      sv_in    = sv_ff;
      dnp_in   = dnp_ff;
      dnv_in   = dnv_ff;
      remp_in  = remp_ff;
      remv_in  = remv_ff;
      stage_in = stage_ff;
      sat_in   = sat_ff;
      prod_in  = ctrl.uw.mul_en ? ma * mb : prod_ff;
      opos_in  = opos_ff;
      ovel_in  = ovel_ff;
      osat_in  = osat_ff;
      ovld_in  = ovld_ff && !rsp_ready;

      case (ctrl.uw.wb)
         WB_R: begin
            r_in   = c_wb.val;
            sat_in = sat_in | c_wb.hit;
         end
         WB_KP: begin
            kp_in  = c_wb.val;
            sat_in = sat_in | c_wb.hit;
         end
         WB_KV: begin
            kv_in  = c_wb.val;
            sat_in = sat_in | c_wb.hit;
         end
         default: ;
      endcase

      case (ctrl.uw.op)
         OP_OM: begin
            c_a    = clamp32(40'(QOne) - 40'(r_ff));
            r_in   = c_a.val;
            sat_in = sat_in | c_a.hit;
         end
         OP_DV: begin
            c_a    = clamp32(40'(r_ff) - 40'(tp_ff));
            r_in   = c_a.val;
            sat_in = sat_in | c_a.hit;
         end
         OP_UPD: begin
            sp_in    = base_p + (weight2 ? (kp36 <<< 1) : kp36);
            sv_in    = base_v + (weight2 ? (kv36 <<< 1) : kv36);
            stage_in = stage_ff + 2'd1;
            if (stage_ff != 2'd3) begin
               tp_in  = c_a.val;
               tv_in  = c_b.val;
               sat_in = sat_in | c_a.hit | c_b.hit;
            end
         end
         OP_PREP: begin
            dnp_in  = pre_p[35:0];
            dnv_in  = pre_v[35:0];
            remp_in = 2'd0;
            remv_in = 2'd0;
         end
         OP_DIV: begin
            dnp_in  = {dnp_ff[29:0], dc_p[5:0]};
            dnv_in  = {dnv_ff[29:0], dc_v[5:0]};
            remp_in = dc_p[7:6];
            remv_in = dc_v[7:6];
         end
         OP_FIN: begin
            c_a     = clamp32(40'(pos_ff) + 40'(qp));
            c_b     = clamp32(40'(vel_ff) + 40'(qv));
            pos_in  = c_a.val;
            vel_in  = c_b.val;
            opos_in = c_a.val;
            ovel_in = c_b.val;
            osat_in = sat_ff | c_a.hit | c_b.hit;
            ovld_in = 1'b1;
         end
         default: ;
      endcase

      if (ctrl.accept) begin
         if (ctrl.load) begin
            pos_in  = load_position;
            vel_in  = load_velocity;
            opos_in = load_position;
            ovel_in = load_velocity;
            osat_in = 1'b0;
            ovld_in = 1'b1;
         end else begin
            tp_in    = pos_ff;
            tv_in    = vel_ff;
            stage_in = 2'd0;
            sat_in   = 1'b0;
         end
      end
   end

   assign rsp_valid       = ovld_ff;
   assign new_position    = opos_ff;
   assign new_velocity    = ovel_ff;
   assign saturated       = osat_ff;
   assign stat.last_stage = (stage_ff == 2'd3);
   assign stat.out_free   = !ovld_ff || rsp_ready;

endmodule

@@ hdl/rk4_van_der_pol_step.sv @@
// Load beat: the result is registered and valid in the cycle after the request beat.
// Advance beat: no new request is taken until the result is in the output register.
// The advance runs twenty products through the single 32x32 multiplier
// (eleven sequencer steps per stage) plus a six-step divide by six.
// Reset: position and velocity zero, step 167772 (about 0.01), damping 1.0.
module rk4_van_der_pol_step (
   input  logic        clock,
   input  logic        reset,
   rvdp_req_if.sink    req_bus,
   rvdp_rsp_if.source  rsp_bus,
   rvdp_csr_if.sink    csr_bus
);
   import rvdp_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   rvdp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .stat       (stat),
      .req_ready  (req_bus.ready),
      .ctrl       (ctrl)
   );

   rvdp_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .load_position (req_bus.load_position),
      .load_velocity (req_bus.load_velocity),
      .csr_valid     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .new_position  (rsp_bus.new_position),
      .new_velocity  (rsp_bus.new_velocity),
      .saturated     (rsp_bus.saturated),
      .stat          (stat)
   );

endmodule

@@ verif/rvdp_tb_pkg.sv @@
`timescale 1ns / 100ps

package rvdp_tb_pkg;

   typedef enum logic {
      ACT_ADVANCE = 1'b0,
      ACT_LOAD    = 1'b1
   } action_type;

endpackage

@@ verif/vdp_step_checker.sv @@
`timescale 1ns / 100ps

module vdp_step_checker (
   input  logic  clock,
   input  logic  reset,
   rvdp_req_if   req_bus,
   rvdp_rsp_if   rsp_bus,
   rvdp_csr_if   csr_bus,
   output int    errors,
   output int    states_seen,
   output int    outstanding
);
   import rvdp_pkg::*;
   import rvdp_tb_pkg::*;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic               saturated;
   } vdp_state_type;

   logic signed [31:0] position_q;
   logic signed [31:0] velocity_q;
   logic [24:0]        step_q;
   logic [28:0]        mu_q;
   vdp_state_type      expected_states[$];
   vdp_state_type      want;
   int                 fail_total;
   int                 seen_total;

   function automatic logic signed [63:0] floor_quot(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
      logic signed [63:0] q;
      q = num / den;
      if ((num % den) != 0 && num < 0)
         q = q - 1;
      return q;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                 inout logic hit);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         hit = 1'b1;
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         hit = 1'b1;
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] q24_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout logic hit);
      return clip32(floor_quot(a * b + 64'sd8388608, 64'sd16777216), hit);
   endfunction

   function automatic void vdp_slope(input logic signed [31:0] px,
                                     input logic signed [31:0] vx,
                                     input logic signed [63:0] mu,
                                     output logic signed [31:0] dp,
                                     output logic signed [31:0] dv,
                                     inout logic hit);
      logic signed [31:0] sq;
      logic signed [31:0] om;
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic signed [63:0] wide;
      sq = q24_mul(px, px, hit);
      wide = 64'sd16777216;
      om = clip32(wide - sq, hit);
      t1 = q24_mul(mu, om, hit);
      t2 = q24_mul(t1, vx, hit);
      dp = vx;
      wide = 64'(t2);
      dv = clip32(wide - px, hit);
   endfunction

   function automatic vdp_state_type rk4_advance(input logic signed [31:0] pos,
                                                 input logic signed [31:0] vel,
                                                 input logic [24:0] step,
                                                 input logic [28:0] mu_reg);
      vdp_state_type      r;
      logic signed [63:0] h;
      logic signed [63:0] mu;
      logic signed [63:0] base_p;
      logic signed [63:0] base_v;
      logic signed [31:0] kp[4];
      logic signed [31:0] kv[4];
      logic signed [31:0] tp;
      logic signed [31:0] tv;
      logic signed [31:0] dp;
      logic signed [31:0] dv;
      logic signed [63:0] sp;
      logic signed [63:0] sv;
      logic               hit;
      hit = 1'b0;
      h = 64'(step);
      if (mu_reg == '0)
         mu = 64'sd16777216;
      else
         mu = 64'(mu_reg);
      base_p = 64'(pos);
      base_v = 64'(vel);
      tp = pos;
      tv = vel;
      for (int i = 0; i < 4; i++) begin
         vdp_slope(tp, tv, mu, dp, dv, hit);
         kp[i] = q24_mul(h, dp, hit);
         kv[i] = q24_mul(h, dv, hit);
         if (i < 2) begin
            tp = clip32(base_p + floor_quot(kp[i], 2), hit);
            tv = clip32(base_v + floor_quot(kv[i], 2), hit);
         end else if (i == 2) begin
            tp = clip32(base_p + kp[i], hit);
            tv = clip32(base_v + kv[i], hit);
         end
      end
      sp = 64'(kp[0]);
      sp = sp + 2 * kp[1] + 2 * kp[2] + kp[3];
      sv = 64'(kv[0]);
      sv = sv + 2 * kv[1] + 2 * kv[2] + kv[3];
      r.position = clip32(base_p + floor_quot(sp + 3, 6), hit);
      r.velocity = clip32(base_v + floor_quot(sv + 3, 6), hit);
      r.saturated = hit;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         position_q = '0;
         velocity_q = '0;
         step_q = StepReset;
         mu_q = MuReset;
         expected_states.delete();
         fail_total = 0;
         seen_total = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CsrStep)
               step_q = csr_bus.data[24:0];
            else if (csr_bus.index == CsrMu)
               mu_q = csr_bus.data[28:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.action == ACT_LOAD) begin
               want.position = req_bus.load_position;
               want.velocity = req_bus.load_velocity;
               want.saturated = 1'b0;
            end else begin
               want = rk4_advance(position_q, velocity_q, step_q, mu_q);
            end
            position_q = want.position;
            velocity_q = want.velocity;
            expected_states.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_total++;
            if (expected_states.size() == 0) begin
               $error("result beat with no expected state: position %0d, velocity %0d",
                      rsp_bus.new_position, rsp_bus.new_velocity);
               fail_total++;
            end else begin
               want = expected_states.pop_front();
               if (rsp_bus.new_position !== want.position) begin
                  $error("new_position: expected %0d, got %0d",
                         want.position, rsp_bus.new_position);
                  fail_total++;
               end
               if (rsp_bus.new_velocity !== want.velocity) begin
                  $error("new_velocity: expected %0d, got %0d",
                         want.velocity, rsp_bus.new_velocity);
                  fail_total++;
               end
               if (rsp_bus.saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d",
                         want.saturated, rsp_bus.saturated);
                  fail_total++;
               end
            end
         end
      end
      errors <= fail_total;
      states_seen <= seen_total;
      outstanding <= expected_states.size();
   end

endmodule

@@ verif/tb_rk4_van_der_pol_step.sv @@
`timescale 1ns / 100ps

module tb_rk4_van_der_pol_step;
   import rvdp_pkg::*;
   import rvdp_tb_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int SegItems   = 110;

   logic clock = 1'b0;
   logic reset;
   int   errors;
   int   states_seen;
   int   outstanding;
   int   items_sent = 0;
   int   cycle_count = 0;
   int   req_idle_pct;
   int   rsp_idle_pct;

   rvdp_req_if req_bus();
   rvdp_rsp_if rsp_bus();
   rvdp_csr_if csr_bus();

   rk4_van_der_pol_step i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   vdp_step_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .errors      (errors),
      .states_seen (states_seen),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input action_type act, input logic signed [31:0] px,
                            input logic signed [31:0] vx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.load_position <= px;
      req_bus.load_velocity <= vx;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // hold the request side until every state beat has returned
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (states_seen != items_sent)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_q(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic load_random_setup();
      logic [24:0] step;
      logic [28:0] mu;
      case ($urandom_range(7))
         0: step = '0;
         1: step = '1;
         2: step = 25'(QOne);
         3: step = 25'($urandom_range(1, 25'h1ffffff));
         default: step = 25'($urandom_range(1, 1 << 21));
      endcase
      case ($urandom_range(7))
         0: mu = '0;
         1: mu = '1;
         2: mu = 29'(QOne);
         3: mu = 29'($urandom());
         default: mu = 29'($urandom_range(0, 1 << 26));
      endcase
      csr_write(CsrStep, ($urandom() & ~32'h1ffffff) | 32'(step));
      if ($urandom_range(3) == 0)
         csr_write(CsrIdxW'($urandom_range(CsrMu + 1, (1 << CsrIdxW) - 1)), $urandom());
      csr_write(CsrMu, ($urandom() & ~32'h1fffffff) | 32'(mu));
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int left;
      int run;
      int span;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_ADVANCE;
      req_bus.load_position = '0;
      req_bus.load_velocity = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      req_idle_pct = 15;
      rsp_idle_pct = 47;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_LOAD, QOne, '0);
      send_item(ACT_ADVANCE, '0, '0);
      send_item(ACT_ADVANCE, '1, '1);
      send_item(ACT_LOAD, 32'sh7fffffff, 32'sh7fffffff);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_LOAD, 32'sh80000000, 32'sh80000000);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_LOAD, 32'sh7fffffff, 32'sh80000000);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_LOAD, -(QOne / 2), 3 * QOne);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_ADVANCE, $urandom(), $urandom());

      drain();
      csr_write(CsrStep, 32'hffffffff);
      csr_write(CsrMu, 32'hffffffff);
      csr_write({CsrIdxW{1'b1}}, 32'h00000003);
      csr_bus.valid <= 1'b0;
      send_item(ACT_LOAD, 2 * QOne, -3 * QOne);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_ADVANCE, $urandom(), $urandom());

      drain();
      csr_write(CsrStep, '0);
      csr_bus.valid <= 1'b0;
      send_item(ACT_LOAD, QOne / 2, QOne / 2);
      send_item(ACT_ADVANCE, $urandom(), $urandom());

      drain();
      csr_write(CsrStep, QOne);
      csr_write(CsrMu, '0);
      csr_bus.valid <= 1'b0;
      send_item(ACT_LOAD, QOne, QOne);
      send_item(ACT_ADVANCE, $urandom(), $urandom());
      send_item(ACT_ADVANCE, $urandom(), $urandom());

      drain();
      csr_write(CsrStep, 32'h00000001);
      csr_write(CsrMu, 32'(MuReset));
      csr_bus.valid <= 1'b0;
      send_item(ACT_LOAD, $urandom(), $urandom());
      send_item(ACT_ADVANCE, $urandom(), $urandom());

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            req_idle_pct = 47;
            rsp_idle_pct = 15;
         end else if (phase == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int seg = 0; seg < 5; seg++) begin
            drain();
            load_random_setup();
            left = SegItems;
            while (left > 0) begin
               if ($urandom_range(7) == 0) begin
                  send_item(action_type'($urandom_range(1)), $urandom(), $urandom());
                  left--;
               end else begin
                  span = $urandom_range(1, 16) * (QOne / 4);
                  send_item(ACT_LOAD, rand_q(span), rand_q(span));
                  left--;
                  run = $urandom_range(1, 12);
                  while (run > 0 && left > 0) begin
                     send_item(ACT_ADVANCE, $urandom(), $urandom());
                     run--;
                     left--;
                  end
               end
            end
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/rvdp_pkg.sv
hdl/rvdp_if.sv
hdl/rvdp_seq.sv
hdl/rvdp_dpath.sv
hdl/rk4_van_der_pol_step.sv
verif/rvdp_tb_pkg.sv
verif/vdp_step_checker.sv
verif/tb_rk4_van_der_pol_step.sv
